// ===== hdl/dpb_pkg.sv =====
// Shared types, widths and reset values of the depth pixel back-projection block.
package dpb_pkg;

    localparam int DPB_GRID_STEP   = 4;
    localparam int DPB_STEP_W      = 5;
    localparam int DPB_COORD_W     = 12;
    localparam int DPB_DEPTH_W     = 16;

    localparam int DPB_DU_W        = 17;
    localparam int DPB_PX_W        = 33;
    localparam int DPB_QX_W        = 57;
    localparam int DPB_CAM_SHIFT   = 28;
    localparam int DPB_XC_W        = 29;

    localparam int DPB_COEF_W      = 16;
    localparam int DPB_TRANS_W     = 20;
    localparam int DPB_P_W         = 45;
    localparam int DPB_ACC_W       = 47;
    localparam int DPB_POSE_SHIFT  = 14;
    localparam int DPB_RND_W       = 33;
    localparam int DPB_SUM_W       = 34;
    localparam int DPB_WORLD_W     = 24;

    localparam int DPB_CFG_IDX_W   = 3;
    localparam int DPB_CFG_DATA_W  = 60;

    localparam logic [7:0]  DPB_GREY          = 8'd200;
    localparam logic [31:0] DPB_RST_PP        = 32'd0;
    localparam logic [47:0] DPB_RST_IFOCAL    = 48'd0;
    localparam logic [47:0] DPB_RST_ROT_X     = 48'h0000_0000_4000;
    localparam logic [47:0] DPB_RST_ROT_Y     = 48'h0000_4000_0000;
    localparam logic [47:0] DPB_RST_ROT_Z     = 48'h4000_0000_0000;
    localparam logic [59:0] DPB_RST_TRANS     = 60'd0;
    localparam logic [31:0] DPB_RST_LIMITS    = 32'h1F40_000A;
    localparam logic [1:0]  DPB_RST_ENABLES   = 2'b11;

    typedef enum logic [DPB_CFG_IDX_W-1:0] {
        CFG_PRINCIPAL_POINT = 3'd0,
        CFG_INVERSE_FOCAL   = 3'd1,
        CFG_ROT_ROW_X       = 3'd2,
        CFG_ROT_ROW_Y       = 3'd3,
        CFG_ROT_ROW_Z       = 3'd4,
        CFG_TRANSLATION     = 3'd5,
        CFG_DEPTH_LIMITS    = 3'd6,
        CFG_ENABLES         = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0]       principal_point;
        logic [47:0]       inverse_focal;
        logic [2:0][47:0]  rot;
        logic [59:0]       translation;
        logic [31:0]       depth_limits;
        logic [1:0]        enables;
    } t_cfg;

    typedef struct packed {
        logic [DPB_COORD_W-1:0] column;
        logic [DPB_COORD_W-1:0] pixel_row;
        logic [DPB_DEPTH_W-1:0] depth_mm;
        logic [7:0]             mask_value;
        logic [7:0]             red;
        logic [7:0]             green;
        logic [7:0]             blue;
    } t_in_word;

    typedef struct packed {
        logic signed [DPB_WORLD_W-1:0] world_x;
        logic signed [DPB_WORLD_W-1:0] world_y;
        logic signed [DPB_WORLD_W-1:0] world_z;
        logic [7:0]                    point_red;
        logic [7:0]                    point_green;
        logic [7:0]                    point_blue;
    } t_out_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic signed [DPB_DU_W-1:0] du;
        logic signed [DPB_DU_W-1:0] dv;
        logic [DPB_DEPTH_W-1:0]     depth;
        t_rgb                       rgb;
    } t_pix;

    typedef struct packed {
        logic signed [DPB_XC_W-1:0] xc;
        logic signed [DPB_XC_W-1:0] yc;
        logic [DPB_DEPTH_W-1:0]     zc;
        t_rgb                       rgb;
    } t_cam;

endpackage

// ===== hdl/dpb_filter.sv =====
// Pixel filter stage: sample grid, mask and depth window tests, principal point offset.
module dpb_filter #(
    parameter int GRID_STEP = dpb_pkg::DPB_GRID_STEP
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  dpb_pkg::t_in_word i_word,
    input  dpb_pkg::t_cfg     i_cfg,
    input  logic              i_down_en,
    output logic              o_en,
    output logic              o_valid,
    output dpb_pkg::t_pix     o_data
);
    import dpb_pkg::*;

    localparam int K        = DPB_COORD_W + DPB_STEP_W;
    localparam int RECIP_W  = K + 1;
    localparam int PROD_W   = DPB_COORD_W + RECIP_W;
    localparam int Q_W      = PROD_W - K;
    localparam int QS_W     = Q_W + DPB_STEP_W;
    localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'((1 << K) / GRID_STEP);
    localparam logic [QS_W-1:0]    STEP_Q = QS_W'(GRID_STEP);

    logic                     r_v;
    t_pix                     r_data;
    logic                     n_v;
    t_pix                     n_data;
    logic [PROD_W-1:0]        w_col_prod;
    logic [PROD_W-1:0]        w_row_prod;
    logic [QS_W-1:0]          w_col_rem;
    logic [QS_W-1:0]          w_row_rem;
    logic                     w_grid_ok;
    logic                     w_mask_ok;
    logic                     w_depth_ok;
    logic [DPB_DEPTH_W-1:0]   w_dmin;
    logic [DPB_DEPTH_W-1:0]   w_dmax;

    // reciprocal estimate leaves the remainder in [0, 2*step)
    assign w_col_prod = PROD_W'(i_word.column) * PROD_W'(RECIP);
    assign w_row_prod = PROD_W'(i_word.pixel_row) * PROD_W'(RECIP);
    assign w_col_rem  = QS_W'(i_word.column)
                      - QS_W'(w_col_prod[PROD_W-1:K]) * STEP_Q;
    assign w_row_rem  = QS_W'(i_word.pixel_row)
                      - QS_W'(w_row_prod[PROD_W-1:K]) * STEP_Q;
    assign w_grid_ok  = (w_col_rem == '0 || w_col_rem == STEP_Q)
                     && (w_row_rem == '0 || w_row_rem == STEP_Q);

    assign w_dmin     = i_cfg.depth_limits[15:0];
    assign w_dmax     = i_cfg.depth_limits[31:16];
    assign w_mask_ok  = !(i_cfg.enables[0] && i_word.mask_value != 8'd0);
    assign w_depth_ok = (i_word.depth_mm > w_dmin) && (i_word.depth_mm <= w_dmax);

    always_comb begin
        n_v          = i_valid && w_grid_ok && w_mask_ok && w_depth_ok;
        n_data.du    = $signed({1'b0, i_word.column, 4'b0000})
                     - $signed({1'b0, i_cfg.principal_point[15:0]});
        n_data.dv    = $signed({1'b0, i_word.pixel_row, 4'b0000})
                     - $signed({1'b0, i_cfg.principal_point[31:16]});
        n_data.depth = i_word.depth_mm;
        if (i_cfg.enables[1]) begin
            n_data.rgb.red   = i_word.red;
            n_data.rgb.green = i_word.green;
            n_data.rgb.blue  = i_word.blue;
        end else begin
            n_data.rgb.red   = DPB_GREY;
            n_data.rgb.green = DPB_GREY;
            n_data.rgb.blue  = DPB_GREY;
        end
    end

    assign o_en = !r_v || i_down_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_en) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_data;

endmodule

// ===== hdl/dpb_camera.sv =====
// Pinhole back-projection: depth times offset, times inverse focal, rounded to mm.
module dpb_camera (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  dpb_pkg::t_pix i_data,
    input  dpb_pkg::t_cfg i_cfg,
    input  logic          i_down_en,
    output logic          o_en,
    output logic          o_valid,
    output dpb_pkg::t_cam o_data
);
    import dpb_pkg::*;

    localparam logic signed [DPB_QX_W-1:0] HALF = DPB_QX_W'(1) << (DPB_CAM_SHIFT - 1);

    logic                       r_v2, r_v3, r_v4;
    logic                       w_en2, w_en3, w_en4;
    logic signed [DPB_PX_W-1:0] r_px, r_py;
    logic [DPB_DEPTH_W-1:0]     r_d2, r_d3;
    t_rgb                       r_rgb2, r_rgb3;
    logic signed [DPB_QX_W-1:0] r_qx, r_qy;
    t_cam                       r_cam;
    logic signed [DPB_PX_W:0]   w_px, w_py;
    logic signed [DPB_QX_W:0]   w_qx, w_qy;
    logic signed [DPB_QX_W-1:0] w_sx, w_sy;
    logic signed [DPB_DU_W-1:0] w_d;

    assign w_d  = $signed({1'b0, i_data.depth});
    assign w_px = i_data.du * w_d;
    assign w_py = i_data.dv * w_d;
    assign w_qx = r_px * $signed({1'b0, i_cfg.inverse_focal[23:0]});
    assign w_qy = r_py * $signed({1'b0, i_cfg.inverse_focal[47:24]});
    // round half away from zero
    assign w_sx = r_qx + HALF - DPB_QX_W'(r_qx[DPB_QX_W-1]);
    assign w_sy = r_qy + HALF - DPB_QX_W'(r_qy[DPB_QX_W-1]);

    assign w_en4 = !r_v4 || i_down_en;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign o_en  = w_en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en2) begin
                r_v2 <= i_valid;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_px   <= w_px[DPB_PX_W-1:0];
            r_py   <= w_py[DPB_PX_W-1:0];
            r_d2   <= i_data.depth;
            r_rgb2 <= i_data.rgb;
        end
        if (w_en3) begin
            r_qx   <= w_qx[DPB_QX_W-1:0];
            r_qy   <= w_qy[DPB_QX_W-1:0];
            r_d3   <= r_d2;
            r_rgb3 <= r_rgb2;
        end
        if (w_en4) begin
            r_cam.xc  <= w_sx[DPB_QX_W-1:DPB_CAM_SHIFT];
            r_cam.yc  <= w_sy[DPB_QX_W-1:DPB_CAM_SHIFT];
            r_cam.zc  <= r_d3;
            r_cam.rgb <= r_rgb3;
        end
    end

    assign o_valid = r_v4;
    assign o_data  = r_cam;

endmodule

// ===== hdl/dpb_pose.sv =====
// Camera-to-world pose: rotation products, row sums, rounding, translation and saturation.
module dpb_pose (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  dpb_pkg::t_cam      i_data,
    input  dpb_pkg::t_cfg      i_cfg,
    input  logic               i_out_stall,
    output logic               o_en,
    output logic               o_valid,
    output dpb_pkg::t_out_word o_word
);
    import dpb_pkg::*;

    localparam logic signed [DPB_ACC_W-1:0] HALF = DPB_ACC_W'(1) << (DPB_POSE_SHIFT - 1);
    localparam logic signed [DPB_SUM_W-1:0] SAT_HI = DPB_SUM_W'((1 << (DPB_WORLD_W - 1)) - 1);
    localparam logic signed [DPB_SUM_W-1:0] SAT_LO = ~SAT_HI;

    logic                          r_v5, r_v6, r_v7, r_v8;
    logic                          w_en5, w_en6, w_en7, w_en8;
    logic signed [DPB_P_W-1:0]     r_prod [3][3];
    logic signed [DPB_ACC_W-1:0]   r_acc  [3];
    logic signed [DPB_RND_W-1:0]   r_rnd  [3];
    t_rgb                          r_rgb5, r_rgb6, r_rgb7;
    t_out_word                     r_word;
    logic signed [DPB_COEF_W-1:0]  w_coef [3][3];
    logic signed [DPB_XC_W-1:0]    w_coord[3];
    logic signed [DPB_P_W-1:0]     w_prod [3][3];
    logic signed [DPB_ACC_W-1:0]   w_acc  [3];
    logic signed [DPB_ACC_W-1:0]   w_rs   [3];
    logic signed [DPB_SUM_W-1:0]   w_sum  [3];
    logic signed [DPB_WORLD_W-1:0] w_world[3];
    logic signed [DPB_TRANS_W-1:0] w_t    [3];

    assign w_coord[0] = i_data.xc;
    assign w_coord[1] = i_data.yc;
    assign w_coord[2] = DPB_XC_W'(i_data.zc);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                w_coef[k][j] = i_cfg.rot[k][DPB_COEF_W*j +: DPB_COEF_W];
                w_prod[k][j] = w_coef[k][j] * w_coord[j];
            end
            w_acc[k] = r_prod[k][0] + r_prod[k][1] + r_prod[k][2];
            w_rs[k]  = r_acc[k] + HALF - DPB_ACC_W'(r_acc[k][DPB_ACC_W-1]);
            w_t[k]   = i_cfg.translation[DPB_TRANS_W*k +: DPB_TRANS_W];
            w_sum[k] = r_rnd[k] + w_t[k];
            if (w_sum[k] > SAT_HI) begin
                w_world[k] = SAT_HI[DPB_WORLD_W-1:0];
            end else if (w_sum[k] < SAT_LO) begin
                w_world[k] = SAT_LO[DPB_WORLD_W-1:0];
            end else begin
                w_world[k] = w_sum[k][DPB_WORLD_W-1:0];
            end
        end
    end

    assign w_en8 = !r_v8 || !i_out_stall;
    assign w_en7 = !r_v7 || w_en8;
    assign w_en6 = !r_v6 || w_en7;
    assign w_en5 = !r_v5 || w_en6;
    assign o_en  = w_en5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else begin
            if (w_en5) begin
                r_v5 <= i_valid;
            end
            if (w_en6) begin
                r_v6 <= r_v5;
            end
            if (w_en7) begin
                r_v7 <= r_v6;
            end
            if (w_en8) begin
                r_v8 <= r_v7;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_prod <= w_prod;
            r_rgb5 <= i_data.rgb;
        end
        if (w_en6) begin
            r_acc  <= w_acc;
            r_rgb6 <= r_rgb5;
        end
        if (w_en7) begin
            for (int k = 0; k < 3; k++) begin
                r_rnd[k] <= w_rs[k][DPB_ACC_W-1:DPB_POSE_SHIFT];
            end
            r_rgb7 <= r_rgb6;
        end
        if (w_en8) begin
            r_word.world_x     <= w_world[0];
            r_word.world_y     <= w_world[1];
            r_word.world_z     <= w_world[2];
            r_word.point_red   <= r_rgb7.red;
            r_word.point_green <= r_rgb7.green;
            r_word.point_blue  <= r_rgb7.blue;
        end
    end

    assign o_valid = r_v8;
    assign o_word  = r_word;

endmodule

// ===== hdl/depth_pixel_backprojection.sv =====
// Top level: configuration registers and the filter, camera and pose pipeline.
//
// Depth pixels enter on the input channel (i_in_valid, i_in_word, o_in_stall);
// world points leave on the output channel (o_out_valid, o_out_word,
// i_out_stall). A word moves when valid is high and stall is low.
// A pixel off the sample grid, masked, or outside the depth window yields no
// output word; every other pixel yields exactly one, in order.
// One filter stage, three camera stages (two multiplies and a rounding step)
// and four pose stages (rotation products, row sums, rounding, translation
// with saturation) lie between input and output.
// Throughput is one pixel per cycle while the receiver does not stall; the
// widest multiply, 33 by 25 bits, sets the stage depth.
// Configuration writes use i_cfg_valid, i_cfg_index and i_cfg_data; o_cfg_ready
// is always high. Write only while the pipeline is empty.
// Synchronous reset empties the pipeline and loads the default registers.
// When the receiver stalls, each stage holds its word and bubbles close up, so
// o_in_stall rises only once every stage holds a word.
module depth_pixel_backprojection #(
    parameter int GRID_STEP = dpb_pkg::DPB_GRID_STEP
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  dpb_pkg::t_in_word                   i_in_word,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output dpb_pkg::t_out_word                  o_out_word,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_valid,
    input  logic [dpb_pkg::DPB_CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dpb_pkg::DPB_CFG_DATA_W-1:0]  i_cfg_data,
    output logic                                o_cfg_ready
);
    import dpb_pkg::*;

    t_cfg r_cfg;
    logic w_filt_en, w_filt_valid;
    logic w_cam_en, w_cam_valid;
    logic w_pose_en;
    t_pix w_pix;
    t_cam w_cam;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.principal_point <= DPB_RST_PP;
            r_cfg.inverse_focal   <= DPB_RST_IFOCAL;
            r_cfg.rot[0]          <= DPB_RST_ROT_X;
            r_cfg.rot[1]          <= DPB_RST_ROT_Y;
            r_cfg.rot[2]          <= DPB_RST_ROT_Z;
            r_cfg.translation     <= DPB_RST_TRANS;
            r_cfg.depth_limits    <= DPB_RST_LIMITS;
            r_cfg.enables         <= DPB_RST_ENABLES;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PRINCIPAL_POINT: r_cfg.principal_point <= i_cfg_data[31:0];
                CFG_INVERSE_FOCAL:   r_cfg.inverse_focal   <= i_cfg_data[47:0];
                CFG_ROT_ROW_X:       r_cfg.rot[0]          <= i_cfg_data[47:0];
                CFG_ROT_ROW_Y:       r_cfg.rot[1]          <= i_cfg_data[47:0];
                CFG_ROT_ROW_Z:       r_cfg.rot[2]          <= i_cfg_data[47:0];
                CFG_TRANSLATION:     r_cfg.translation     <= i_cfg_data[59:0];
                CFG_DEPTH_LIMITS:    r_cfg.depth_limits    <= i_cfg_data[31:0];
                CFG_ENABLES:         r_cfg.enables         <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    dpb_filter #(
        .GRID_STEP(GRID_STEP)
    ) u_filter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_word    (i_in_word),
        .i_cfg     (r_cfg),
        .i_down_en (w_cam_en),
        .o_en      (w_filt_en),
        .o_valid   (w_filt_valid),
        .o_data    (w_pix)
    );

    dpb_camera u_camera (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_filt_valid),
        .i_data    (w_pix),
        .i_cfg     (r_cfg),
        .i_down_en (w_pose_en),
        .o_en      (w_cam_en),
        .o_valid   (w_cam_valid),
        .o_data    (w_cam)
    );

    dpb_pose u_pose (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_cam_valid),
        .i_data      (w_cam),
        .i_cfg       (r_cfg),
        .i_out_stall (i_out_stall),
        .o_en        (w_pose_en),
        .o_valid     (o_out_valid),
        .o_word      (o_out_word)
    );

    assign o_in_stall = !w_filt_en;

endmodule
